[rtl/core/sha_pkg.sv]
// Shared types, constants and round tables for the SHA-256 stream hash.
package sha_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int BLOCK_WORDS = 16;
   localparam int ROUNDS = 64;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] data_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef struct packed {
      logic [31:0] word;
      logic        msg_end;
   } qword_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } fifo_status_type;

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_PAD_FIRST,
      FR_PAD_ZERO,
      FR_LEN_HI,
      FR_LEN_LO
   } front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ROUND,
      BK_ADD,
      BK_EMIT
   } back_state_type;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

[rtl/core/sha_fifo.sv]
// Short word queue between the byte packer and the compression engine.
module sha_fifo #(
   parameter int Depth = sha_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  sha_pkg::qword_type          push_data,
   input  logic                        pop,
   output sha_pkg::qword_type          pop_data,
   output sha_pkg::fifo_status_type    status
);
   import sha_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   qword_type       mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign status.full      = (cnt_ff == CntW'(Depth));
   assign status.not_empty = (cnt_ff != '0);
   assign pop_data         = mem_ff[rd_ptr_ff];
   assign do_push          = push && !status.full;
   assign do_pop           = pop && status.not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/sha_front.sv]
// Byte packer and padding generator that feeds big-endian words to the queue.
module sha_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  sha_pkg::req_type          req_data,
   input  sha_pkg::fifo_status_type  q_status,
   output logic                      q_push,
   output sha_pkg::qword_type        q_data
);
   import sha_pkg::*;

   front_state_type state_ff, state_in;
   logic [60:0]     count_ff, count_in;
   logic [23:0]     part_ff, part_in;
   logic [3:0]      pidx_ff, pidx_in;
   logic [31:0]     pad_first;
   logic [31:0]     packed_word;
   logic            accept;

   assign accept      = (state_ff == FR_IDLE) && !q_status.full && req_valid;
   assign packed_word = {part_ff, req_data.data_byte};

   always_comb begin
      case (count_ff[1:0])
         2'd0:    pad_first = 32'h8000_0000;
         2'd1:    pad_first = {part_ff[7:0], 8'h80, 16'h0000};
         2'd2:    pad_first = {part_ff[15:0], 8'h80, 8'h00};
         default: pad_first = {part_ff[23:0], 8'h80};
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_IDLE: begin
            if (accept && req_data.end_of_message) begin
               state_in = FR_PAD_FIRST;
            end
         end
         FR_PAD_FIRST: begin
            if (!q_status.full) begin
               state_in = (pidx_ff == 4'd13) ? FR_LEN_HI : FR_PAD_ZERO;
            end
         end
         FR_PAD_ZERO: begin
            if (!q_status.full && pidx_ff == 4'd13) begin
               state_in = FR_LEN_HI;
            end
         end
         FR_LEN_HI: begin
            if (!q_status.full) begin
               state_in = FR_LEN_LO;
            end
         end
         FR_LEN_LO: begin
            if (!q_status.full) begin
               state_in = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   always_comb begin
      req_stall      = !((state_ff == FR_IDLE) && !q_status.full);
      q_push         = 1'b0;
      q_data.word    = packed_word;
      q_data.msg_end = 1'b0;
      unique case (state_ff)
         FR_IDLE: begin
            q_push = accept && req_data.has_byte && (count_ff[1:0] == 2'b11);
         end
         FR_PAD_FIRST: begin
            q_push      = 1'b1;
            q_data.word = pad_first;
         end
         FR_PAD_ZERO: begin
            q_push      = 1'b1;
            q_data.word = '0;
         end
         FR_LEN_HI: begin
            q_push      = 1'b1;
            q_data.word = count_ff[60:29];
         end
         FR_LEN_LO: begin
            q_push         = 1'b1;
            q_data.word    = {count_ff[28:0], 3'b000};
            q_data.msg_end = 1'b1;
         end
         default: q_push = 1'b0;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      part_in  = part_ff;
      pidx_in  = pidx_ff;
      if (accept && req_data.has_byte) begin
         count_in = count_ff + 61'd1;
         part_in  = packed_word[23:0];
      end
      if (accept && req_data.end_of_message) begin
         pidx_in = count_in[5:2];
      end
      if (state_ff != FR_IDLE && !q_status.full) begin
         pidx_in = pidx_ff + 4'd1;
      end
      if (state_ff == FR_LEN_LO && !q_status.full) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         count_ff <= '0;
         pidx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pidx_ff  <= pidx_in;
      end
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
   end

endmodule

[rtl/core/sha_back.sv]
// Compression engine with a block load buffer, chaining words and digest output.
module sha_back (
   input  logic                      clock,
   input  logic                      reset,
   input  sha_pkg::fifo_status_type  q_status,
   input  sha_pkg::qword_type        q_data,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output sha_pkg::rsp_type          rsp_data
);
   import sha_pkg::*;

   back_state_type state_ff, state_in;
   logic [31:0]    load_ff [BLOCK_WORDS];
   logic [31:0]    load_in [BLOCK_WORDS];
   logic [4:0]     load_cnt_ff, load_cnt_in;
   logic           load_end_ff, load_end_in;
   logic           blk_end_ff, blk_end_in;
   logic [31:0]    win_ff [BLOCK_WORDS];
   logic [31:0]    win_in [BLOCK_WORDS];
   logic [31:0]    var_ff [8];
   logic [31:0]    var_in [8];
   logic [31:0]    chain_ff [8];
   logic [31:0]    chain_in [8];
   logic [5:0]     rnd_ff, rnd_in;
   logic [2:0]     idx_ff, idx_in;
   logic           start;
   logic [31:0]    w_next, x1, x14, ssig0, ssig1;
   logic [31:0]    bsig0, bsig1, ch, maj, t1, t2;

   assign start = (state_ff == BK_IDLE) && load_cnt_ff[4];

   assign x1     = win_ff[1];
   assign x14    = win_ff[14];
   assign ssig0  = ror32(x1, 7) ^ ror32(x1, 18) ^ (x1 >> 3);
   assign ssig1  = ror32(x14, 17) ^ ror32(x14, 19) ^ (x14 >> 10);
   assign w_next = win_ff[0] + ssig0 + win_ff[9] + ssig1;

   assign bsig1 = ror32(var_ff[4], 6) ^ ror32(var_ff[4], 11) ^ ror32(var_ff[4], 25);
   assign ch    = (var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]);
   assign t1    = var_ff[7] + bsig1 + ch + ROUND_K[rnd_ff] + win_ff[0];
   assign bsig0 = ror32(var_ff[0], 2) ^ ror32(var_ff[0], 13) ^ ror32(var_ff[0], 22);
   assign maj   = (var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]);
   assign t2    = bsig0 + maj;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (start) begin
               state_in = BK_ROUND;
            end
         end
         BK_ROUND: begin
            if (rnd_ff == 6'(ROUNDS - 1)) begin
               state_in = BK_ADD;
            end
         end
         BK_ADD: begin
            state_in = blk_end_ff ? BK_EMIT : BK_IDLE;
         end
         BK_EMIT: begin
            if (!rsp_stall && idx_ff == 3'd7) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop                = !load_cnt_ff[4] && q_status.not_empty;
      rsp_valid            = (state_ff == BK_EMIT);
      rsp_data.digest_word = chain_ff[idx_ff];
      rsp_data.word_index  = idx_ff;
      rsp_data.last_word   = (idx_ff == 3'd7);
   end

   always_comb begin
      load_in     = load_ff;
      load_cnt_in = load_cnt_ff;
      load_end_in = load_end_ff;
      blk_end_in  = blk_end_ff;
      win_in      = win_ff;
      var_in      = var_ff;
      chain_in    = chain_ff;
      rnd_in      = rnd_ff;
      idx_in      = idx_ff;
      if (q_pop) begin
         load_in[load_cnt_ff[3:0]] = q_data.word;
         load_cnt_in               = load_cnt_ff + 5'd1;
         if (load_cnt_ff[3:0] == 4'd15) begin
            load_end_in = q_data.msg_end;
         end
      end
      unique case (state_ff)
         BK_IDLE: begin
            if (start) begin
               win_in      = load_ff;
               var_in      = chain_ff;
               blk_end_in  = load_end_ff;
               load_cnt_in = '0;
               rnd_in      = '0;
            end
         end
         BK_ROUND: begin
            for (int j = 0; j < BLOCK_WORDS - 1; j++) begin
               win_in[j] = win_ff[j + 1];
            end
            win_in[BLOCK_WORDS - 1] = w_next;
            var_in[7] = var_ff[6];
            var_in[6] = var_ff[5];
            var_in[5] = var_ff[4];
            var_in[4] = var_ff[3] + t1;
            var_in[3] = var_ff[2];
            var_in[2] = var_ff[1];
            var_in[1] = var_ff[0];
            var_in[0] = t1 + t2;
            rnd_in    = rnd_ff + 6'd1;
         end
         BK_ADD: begin
            for (int j = 0; j < 8; j++) begin
               chain_in[j] = chain_ff[j] + var_ff[j];
            end
            idx_in = '0;
         end
         BK_EMIT: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  chain_in = INIT_HASH;
               end
            end
         end
         default: idx_in = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_IDLE;
         load_cnt_ff <= '0;
         chain_ff    <= INIT_HASH;
         rnd_ff      <= '0;
         idx_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         chain_ff    <= chain_in;
         rnd_ff      <= rnd_in;
         idx_ff      <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      load_ff     <= load_in;
      load_end_ff <= load_end_in;
      blk_end_ff  <= blk_end_in;
      win_ff      <= win_in;
      var_ff      <= var_in;
   end

endmodule

[rtl/core/sha256_stream_hash.sv]
// Top level of the SHA-256 stream hash: byte packer, word queue and compression engine.
// A byte is accepted while the packer is idle and the word queue is not full.
// Each 64-byte block passes through the round engine as a load, 64 rounds and a chaining add;
// the load buffer collects the next block meanwhile. The end of a message adds padding and length words.
// The eight digest words follow the last compression at one per cycle while rsp_stall is low.
// Synchronous reset restores the initial hash and clears counts.
module sha256_stream_hash #(
   parameter int QueueDepth = sha_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sha_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sha_pkg::rsp_type rsp_data
);
   import sha_pkg::*;

   fifo_status_type q_status;
   qword_type       q_wdata;
   qword_type       q_rdata;
   logic            q_push;
   logic            q_pop;

   sha_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_data    (q_wdata)
   );

   sha_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .status    (q_status)
   );

   sha_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_data    (q_rdata),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
